FILE: design/l4hec_pkg.sv
package l4hec_pkg;

  localparam int HDR_ADDR_W = 8;

  // Item modes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ADJ  = 2'd1;
  localparam logic [1:0] MODE_RAW  = 2'd2;
  localparam logic [1:0] MODE_READ = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOPROTO = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // IP versions and header sizes
  localparam logic [3:0] IP_VER4 = 4'd4;
  localparam logic [3:0] IP_VER6 = 4'd6;
  localparam logic [7:0] IP6_HDR_BYTES = 8'd40;

  // Protocol numbers and checksum offsets in the transport header
  localparam logic [7:0] PROTO_ICMP  = 8'd1;
  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [7:0] PROTO_ICMP6 = 8'd58;
  localparam logic [7:0] CS_OFF_UDP  = 8'd6;
  localparam logic [7:0] CS_OFF_TCP  = 8'd16;
  localparam logic [7:0] CS_OFF_ICMP = 8'd2;

  // Store bytes mirrored in registers for header decode
  localparam logic [7:0] ADDR_VER   = 8'd0;
  localparam logic [7:0] ADDR_NH6   = 8'd6;
  localparam logic [7:0] ADDR_PROTO = 8'd9;

  // Write source select
  localparam logic [1:0] WS_OFF   = 2'd0;
  localparam logic [1:0] WS_ADDR  = 2'd1;
  localparam logic [1:0] WS_CS_HI = 2'd2;
  localparam logic [1:0] WS_CS_LO = 2'd3;

  // Read address select
  localparam logic [1:0] RS_ADDR = 2'd0;
  localparam logic [1:0] RS_CA   = 2'd1;
  localparam logic [1:0] RS_CA1  = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] byte_offset;
    logic [7:0] data_byte;
    logic       last_of_access;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [1:0] status;
    logic       access_done;
  } result_t;

  typedef struct packed {
    logic       take;
    logic       calc_en;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic [1:0] rd_sel;
    logic       cap_old;
    logic       cap_hi;
    logic       sum1_en;
    logic       sum2_en;
    logic       cap_rb;
    logic       res_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       off_ok;
    logic       addr_ok;
    logic       cs_known;
    logic       cs_ok;
  } stat_t;

endpackage

FILE: design/l4_header_edit_checksum_fixup.sv
// Loads, raw or unadjusted writes and out-of-range items go from decode straight to the
// result; reads add a store read, and a write with checksum update adds store reads, the
// checksum add and three store writes. A new item is accepted only after the result of
// the last one is loaded, while that result may still wait. The store has one read port and one write port.
// Reset: rst clears the controller, the output valid and the header decode bytes; the
// store itself is not cleared.
module l4_header_edit_checksum_fixup #(
  parameter int BUF_BYTES = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  l4hec_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_ready,
  output l4hec_pkg::result_t  result
);

  // Controller steps each transaction through decode, store reads, the
  // incremental checksum add and up to three store writes.
  l4hec_pkg::cmd_t  cmd;
  l4hec_pkg::stat_t stat;

  l4hec_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Datapath holds the header store, the decode mirrors and the result register.
  l4hec_dp #(
    .BUF_BYTES (BUF_BYTES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule

FILE: design/l4hec_ctrl.sv
module l4hec_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              result_valid,
  input  logic              result_ready,
  input  l4hec_pkg::stat_t  stat,
  output l4hec_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CALC = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_RD0  = 4'd3;
  localparam logic [3:0] S_RD1  = 4'd4;
  localparam logic [3:0] S_RD2  = 4'd5;
  localparam logic [3:0] S_SUM  = 4'd6;
  localparam logic [3:0] S_WR0  = 4'd7;
  localparam logic [3:0] S_WR1  = 4'd8;
  localparam logic [3:0] S_WR2  = 4'd9;
  localparam logic [3:0] S_CAPR = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       result_valid_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.rd_sel = l4hec_pkg::RS_ADDR;
    cmd.wr_sel = l4hec_pkg::WS_ADDR;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.take = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc_en = 1'b1;
        state_next = S_DISP;
      end
      S_DISP: begin
        state_next = S_FIN;
        priority if (stat.mode == l4hec_pkg::MODE_LOAD) begin
          cmd.wr_en = stat.off_ok;
          cmd.wr_sel = l4hec_pkg::WS_OFF;
        end else if (!stat.addr_ok) begin
          state_next = S_FIN;
        end else if (stat.mode == l4hec_pkg::MODE_RAW) begin
          cmd.wr_en = 1'b1;
        end else if (stat.mode == l4hec_pkg::MODE_READ) begin
          state_next = S_RD0;
        end else if (!stat.cs_known) begin
          cmd.wr_en = 1'b1;
        end else if (stat.cs_ok) begin
          state_next = S_RD0;
        end
      end
      S_RD0: begin
        cmd.rd_sel = l4hec_pkg::RS_ADDR;
        state_next = (stat.mode == l4hec_pkg::MODE_READ) ? S_CAPR : S_RD1;
      end
      S_RD1: begin
        cmd.rd_sel = l4hec_pkg::RS_CA;
        cmd.cap_old = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd_sel = l4hec_pkg::RS_CA1;
        cmd.cap_hi = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum1_en = 1'b1;
        state_next = S_WR0;
      end
      S_WR0: begin
        cmd.wr_en = 1'b1;
        cmd.sum2_en = 1'b1;
        state_next = S_WR1;
      end
      S_WR1: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = l4hec_pkg::WS_CS_HI;
        state_next = S_WR2;
      end
      S_WR2: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = l4hec_pkg::WS_CS_LO;
        state_next = S_FIN;
      end
      S_CAPR: begin
        cmd.cap_rb = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold here until the output register is free
        if (!result_valid || result_ready) begin
          cmd.res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (cmd.res_load) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

FILE: design/l4hec_dp.sv
module l4hec_dp #(
  parameter int BUF_BYTES = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  l4hec_pkg::item_t    item,
  input  l4hec_pkg::cmd_t     cmd,
  output l4hec_pkg::stat_t    stat,
  output l4hec_pkg::result_t  result
);

  localparam int AW = $clog2(BUF_BYTES);
  localparam int HW = l4hec_pkg::HDR_ADDR_W;

  logic [7:0]    store [BUF_BYTES];
  logic [7:0]    mem_q;

  l4hec_pkg::item_t it;
  logic [7:0]    b0;
  logic [7:0]    b6;
  logic [7:0]    b9;

  // decode
  logic [HW-1:0] hlen;
  logic [7:0]    proto;
  logic [HW-1:0] coff;
  logic          known;
  logic [HW-1:0] addr_c;
  logic [HW-1:0] ca_c;
  logic          off_ok_c;
  logic          addr_ok_c;
  logic          cs_ok_c;
  logic [7:0]    rb_c;
  logic [1:0]    st_c;

  logic [HW-1:0] addr;
  logic [HW-1:0] ca;
  logic [7:0]    rb;
  logic [1:0]    st;

  logic [7:0]    old_byte;
  logic [7:0]    hc_hi;
  logic [15:0]   f1;
  logic [15:0]   csum;

  logic [15:0]   hc;
  logic [15:0]   m_old;
  logic [15:0]   m_new;
  logic [16:0]   s1;
  logic [15:0]   f1_c;
  logic [16:0]   s2;
  logic [15:0]   csum_c;

  logic [HW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [HW-1:0] rd_addr;

  always_comb begin
    hlen = '0;
    proto = '0;
    if (b0[7:4] == l4hec_pkg::IP_VER4) begin
      hlen = {2'b00, b0[3:0], 2'b00};
      proto = b9;
    end else if (b0[7:4] == l4hec_pkg::IP_VER6) begin
      hlen = l4hec_pkg::IP6_HDR_BYTES;
      proto = b6;
    end
  end

  always_comb begin
    known = 1'b1;
    unique case (proto)
      l4hec_pkg::PROTO_UDP:   coff = l4hec_pkg::CS_OFF_UDP;
      l4hec_pkg::PROTO_TCP:   coff = l4hec_pkg::CS_OFF_TCP;
      l4hec_pkg::PROTO_ICMP,
      l4hec_pkg::PROTO_ICMP6: coff = l4hec_pkg::CS_OFF_ICMP;
      default: begin
        coff = '0;
        known = 1'b0;
      end
    endcase
  end

  assign addr_c    = hlen + {1'b0, it.byte_offset};
  assign ca_c      = hlen + coff;
  assign off_ok_c  = (32'(it.byte_offset) < BUF_BYTES);
  assign addr_ok_c = (32'(addr_c) < BUF_BYTES);
  assign cs_ok_c   = ((32'(ca_c) + 32'd1) < BUF_BYTES);

  // result for every case that needs no store read
  always_comb begin
    rb_c = it.data_byte;
    st_c = l4hec_pkg::ST_OK;
    if (it.mode == l4hec_pkg::MODE_LOAD) begin
      if (!off_ok_c) begin
        rb_c = '0;
        st_c = l4hec_pkg::ST_RANGE;
      end
    end else if (!addr_ok_c) begin
      rb_c = '0;
      st_c = l4hec_pkg::ST_RANGE;
    end else if (it.mode == l4hec_pkg::MODE_ADJ) begin
      if (!known) begin
        st_c = l4hec_pkg::ST_NOPROTO;
      end else if (!cs_ok_c) begin
        rb_c = '0;
        st_c = l4hec_pkg::ST_RANGE;
      end
    end
  end

  // RFC 1624: HC' = ~(~HC + ~m + m'), end-around carry after each add
  assign hc     = {hc_hi, mem_q};
  assign m_old  = it.byte_offset[0] ? {8'h00, old_byte} : {old_byte, 8'h00};
  assign m_new  = it.byte_offset[0] ? {8'h00, it.data_byte} : {it.data_byte, 8'h00};
  assign s1     = {1'b0, ~hc} + {1'b0, ~m_old};
  assign f1_c   = s1[15:0] + {15'd0, s1[16]};
  assign s2     = {1'b0, f1} + {1'b0, m_new};
  assign csum_c = ~(s2[15:0] + {15'd0, s2[16]});

  always_comb begin
    unique case (cmd.wr_sel)
      l4hec_pkg::WS_OFF: begin
        wr_addr = {1'b0, it.byte_offset};
        wr_data = it.data_byte;
      end
      l4hec_pkg::WS_ADDR: begin
        wr_addr = addr;
        wr_data = it.data_byte;
      end
      l4hec_pkg::WS_CS_HI: begin
        wr_addr = ca;
        wr_data = csum[15:8];
      end
      default: begin
        wr_addr = ca + HW'(1);
        wr_data = csum[7:0];
      end
    endcase
  end

  always_comb begin
    unique case (cmd.rd_sel)
      l4hec_pkg::RS_CA:  rd_addr = ca;
      l4hec_pkg::RS_CA1: rd_addr = ca + HW'(1);
      default:           rd_addr = addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[AW'(wr_addr)] <= wr_data;
    end
    mem_q <= store[AW'(rd_addr)];
  end

  // mirror of the bytes that decode the IP header
  always_ff @(posedge clk) begin
    if (rst) begin
      b0 <= '0;
      b6 <= '0;
      b9 <= '0;
    end else if (cmd.wr_en) begin
      if (wr_addr == l4hec_pkg::ADDR_VER) begin
        b0 <= wr_data;
      end
      if (wr_addr == l4hec_pkg::ADDR_NH6) begin
        b6 <= wr_data;
      end
      if (wr_addr == l4hec_pkg::ADDR_PROTO) begin
        b9 <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it <= item;
    end
    if (cmd.calc_en) begin
      addr <= addr_c;
      ca <= ca_c;
      stat.mode <= it.mode;
      stat.off_ok <= off_ok_c;
      stat.addr_ok <= addr_ok_c;
      stat.cs_known <= known;
      stat.cs_ok <= cs_ok_c;
      rb <= rb_c;
      st <= st_c;
    end
    if (cmd.cap_old) begin
      old_byte <= mem_q;
    end
    if (cmd.cap_hi) begin
      hc_hi <= mem_q;
    end
    if (cmd.sum1_en) begin
      f1 <= f1_c;
    end
    if (cmd.sum2_en) begin
      csum <= csum_c;
      // the checksum is written last, so it wins on overlap
      if (addr == ca) begin
        rb <= csum_c[15:8];
      end else if (addr == ca + HW'(1)) begin
        rb <= csum_c[7:0];
      end
    end
    if (cmd.cap_rb) begin
      rb <= mem_q;
    end
    if (cmd.res_load) begin
      result.read_byte <= rb;
      result.status <= st;
      result.access_done <= it.last_of_access;
    end
  end

endmodule
